FILE: sv/skse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key set package
// Request codes, key width and the control word shared by the cell chain.
// ----------------------------------------------------------------------------
package skse_pkg;

    localparam int KEY_W = 16;
    localparam int MODE_W = 2;

    // Keys compared per first-level group of the match tree.
    localparam int GRP_SIZE = 32;

    localparam logic [MODE_W-1:0] MODE_MEMBER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    // Control word broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp;   // capture the less-than flag against the broadcast key
        logic ins;   // open a slot at the insert position and shift up
        logic del;   // close the slot of the matching key and shift down
    } cell_ctrl_t;

endpackage : skse_pkg
`default_nettype wire

FILE: sv/skse_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key set cell
// Holds one slot of the sorted key list and trades keys with its neighbors.
// ----------------------------------------------------------------------------
module skse_cell #(
    parameter int unsigned INDEX = 0,
    parameter int          CNT_W = 11
) (
    input  wire                          clk,
    input  wire skse_pkg::cell_ctrl_t    ctrl,
    input  wire [skse_pkg::KEY_W-1:0]    key,
    input  wire [CNT_W-1:0]              count,
    input  wire                          prev_lt,
    input  wire [skse_pkg::KEY_W-1:0]    prev_key,
    input  wire [skse_pkg::KEY_W-1:0]    next_key,
    output logic [skse_pkg::KEY_W-1:0]   key_q,
    output logic                         lt_q,
    output logic                         eq
);

    logic [skse_pkg::KEY_W-1:0] key_reg;
    logic [skse_pkg::KEY_W-1:0] key_next;
    logic                       lt_reg;
    logic                       lt_next;
    logic                       occupied;
    logic                       lt_now;

    always_comb
    begin
        occupied = CNT_W'(INDEX) < count;
        eq       = occupied && (key_reg == key);
        lt_now   = occupied && (key_reg < key);
        lt_next  = ctrl.cmp ? lt_now : lt_reg;

        // Cells at or above the insert/delete position move; the rest hold.
        key_next = key_reg;
        if (ctrl.ins && !lt_reg)
        begin
            key_next = prev_lt ? key : prev_key;
        end
        else if (ctrl.del && !lt_reg)
        begin
            key_next = next_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        lt_reg  <= lt_next;
    end

    assign key_q = key_reg;
    assign lt_q  = lt_reg;

endmodule : skse_cell
`default_nettype wire

FILE: sv/sorted_key_set_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key set engine
// Member, insert and delete on an ascending set of distinct keys held in a
// chain of cells, one key per cell.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Direction  Payload
//  --------  -------------------------------  ---------  -------------------------
//  request   in_valid, in_ready               in         mode, key
//  result    out_valid, out_ready             out        success, set_full, key_count
//
// A request passes through the transfer cycle, which also estimates the
// quotient of the key by KEY_RANGE with a reciprocal multiplication, a reduce
// cycle that subtracts the quotient multiple and corrects the remainder with
// one compare and subtract, a compare cycle in which every cell checks its key
// against the request key and the match flags are folded into group
// registers, and an apply cycle that shifts the chain, updates the count and
// loads the result register.
// The reset clears the key count and the control state; cell contents are
// meaningless above the count and are never read there.
// The apply cycle waits while a previous result is still held in the output
// register; a new request is taken as soon as the engine is back in idle,
// even if the last result has not yet been transferred.
// ----------------------------------------------------------------------------
module sorted_key_set_engine #(
    parameter int          CAPACITY  = 1024,
    parameter logic [32:0] KEY_RANGE = 33'd65536,
    localparam int         CNT_W     = $clog2(CAPACITY + 1)
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire [skse_pkg::MODE_W-1:0]         mode,
    input  wire [skse_pkg::KEY_W-1:0]          key,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic                               success,
    output logic                               set_full,
    output logic [CNT_W-1:0]                   key_count
);

    localparam int          NGRP     = (CAPACITY + skse_pkg::GRP_SIZE - 1) / skse_pkg::GRP_SIZE;

    // A range at or above the key space leaves every key as it is.
    localparam bit          KEEP_KEY = KEY_RANGE >= (33'd1 << skse_pkg::KEY_W);
    localparam logic [31:0] RECIP    = 32'(64'h1_0000_0000 / 64'(KEY_RANGE));
    localparam logic [skse_pkg::KEY_W-1:0] RANGE_K = KEY_RANGE[skse_pkg::KEY_W-1:0];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_COMPARE,
        ST_APPLY
    } state_t;

    // Quotient estimate by reciprocal multiplication. It is never above the
    // true quotient and at most one below it.
    function automatic logic [skse_pkg::KEY_W-1:0] quot_est(
        input logic [skse_pkg::KEY_W-1:0] v
    );
        logic [skse_pkg::KEY_W+31:0] p;
        p = {32'd0, v} * {{skse_pkg::KEY_W{1'b0}}, RECIP};
        return p[skse_pkg::KEY_W+31:32];
    endfunction

    // Remainder from the estimate: it lies below twice the range, so one
    // compare and subtract finishes it.
    function automatic logic [skse_pkg::KEY_W-1:0] rem_fix(
        input logic [skse_pkg::KEY_W-1:0] v,
        input logic [skse_pkg::KEY_W-1:0] q
    );
        logic [2*skse_pkg::KEY_W-1:0] qr;
        logic [skse_pkg::KEY_W:0]     r;
        qr = {{skse_pkg::KEY_W{1'b0}}, q} * {{skse_pkg::KEY_W{1'b0}}, RANGE_K};
        r  = {1'b0, v} - qr[skse_pkg::KEY_W:0];
        if (r >= {1'b0, RANGE_K})
        begin
            r = r - {1'b0, RANGE_K};
        end
        return KEEP_KEY ? v : r[skse_pkg::KEY_W-1:0];
    endfunction

    state_t                         state_reg;
    logic [skse_pkg::MODE_W-1:0]    mode_reg;
    logic [skse_pkg::KEY_W-1:0]     key_reg;
    logic [skse_pkg::KEY_W-1:0]     quot_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [NGRP-1:0]                grp_reg;
    logic [NGRP-1:0]                grp_next;
    logic                           out_valid_reg;
    logic                           success_reg;
    logic                           set_full_reg;
    logic [CNT_W-1:0]               key_count_reg;

    logic [skse_pkg::KEY_W-1:0]     cell_key [CAPACITY];
    logic [CAPACITY-1:0]            cell_lt;
    logic [CAPACITY-1:0]            cell_eq;
    logic [NGRP*skse_pkg::GRP_SIZE-1:0] eq_pad;
    skse_pkg::cell_ctrl_t           ctrl;

    logic                           out_free;
    logic                           found;
    logic                           full;
    logic                           do_ins;
    logic                           do_del;
    logic                           res_success;
    logic                           res_full;
    logic [CNT_W-1:0]               count_next;

    // ------------------------------------------------------------------
    // Decision logic for the apply cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        found    = |grp_reg;
        full     = count_reg == CNT_W'(CAPACITY);
        do_ins   = 1'b0;
        do_del   = 1'b0;
        res_success = 1'b0;
        res_full    = 1'b0;
        unique case (mode_reg)
            skse_pkg::MODE_MEMBER:
            begin
                res_success = found;
            end
            skse_pkg::MODE_INSERT:
            begin
                do_ins      = !found && !full;
                res_success = do_ins;
                res_full    = !found && full;
            end
            skse_pkg::MODE_DELETE:
            begin
                do_del      = found;
                res_success = found;
            end
            default:
            begin
                res_success = 1'b0;
            end
        endcase

        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_del)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        ctrl.cmp = state_reg == ST_COMPARE;
        ctrl.ins = (state_reg == ST_APPLY) && out_free && do_ins;
        ctrl.del = (state_reg == ST_APPLY) && out_free && do_del;
    end

    // First level of the match tree: one OR per group of cells.
    always_comb
    begin
        eq_pad = '0;
        eq_pad[CAPACITY-1:0] = cell_eq;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = |eq_pad[g*skse_pkg::GRP_SIZE +: skse_pkg::GRP_SIZE];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer, count and result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= '0;
            key_reg       <= '0;
            quot_reg      <= '0;
            count_reg     <= '0;
            grp_reg       <= '0;
            out_valid_reg <= 1'b0;
            success_reg   <= 1'b0;
            set_full_reg  <= 1'b0;
            key_count_reg <= '0;
        end
        else
        begin
            // In the apply cycle the result register reloads instead.
            if (out_valid_reg && out_ready && state_reg != ST_APPLY)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg  <= mode;
                        key_reg   <= key;
                        quot_reg  <= quot_est(key);
                        state_reg <= ST_REDUCE;
                    end
                end
                ST_REDUCE:
                begin
                    key_reg   <= rem_fix(key_reg, quot_reg);
                    state_reg <= ST_COMPARE;
                end
                ST_COMPARE:
                begin
                    grp_reg   <= grp_next;
                    state_reg <= ST_APPLY;
                end
                ST_APPLY:
                begin
                    if (out_free)
                    begin
                        count_reg     <= count_next;
                        success_reg   <= res_success;
                        set_full_reg  <= res_full;
                        key_count_reg <= count_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Cell chain: cell 0 holds the smallest key
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                       prev_lt;
        logic [skse_pkg::KEY_W-1:0] prev_key;
        logic [skse_pkg::KEY_W-1:0] next_key;

        if (i == 0)
        begin : g_first
            assign prev_lt  = 1'b1;
            assign prev_key = '0;
        end
        else
        begin : g_inner
            assign prev_lt  = cell_lt[i-1];
            assign prev_key = cell_key[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_key = cell_key[i];
        end
        else
        begin : g_body
            assign next_key = cell_key[i+1];
        end

        skse_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .key      (key_reg),
            .count    (count_reg),
            .prev_lt  (prev_lt),
            .prev_key (prev_key),
            .next_key (next_key),
            .key_q    (cell_key[i]),
            .lt_q     (cell_lt[i]),
            .eq       (cell_eq[i])
        );
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;
    assign success   = success_reg;
    assign set_full  = set_full_reg;
    assign key_count = key_count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("key count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == $past(count_reg) || count_reg == $past(count_reg) + CNT_W'(1) ||
        count_reg == $past(count_reg) - CNT_W'(1))
        else $error("key count moved by more than one");

    a_excl_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(success && set_full))
        else $error("success and full flag both set");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && set_full) |-> key_count == CNT_W'(CAPACITY))
        else $error("full flag with set not at capacity");

    a_load_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_APPLY))
        else $error("result loaded outside the apply cycle");

endmodule : sorted_key_set_engine
`default_nettype wire

FILE: bench/tb_sorted_key_set_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key set engine testbench
// Runs member, insert and delete requests through the engine against a
// shadow copy of the key set. Covers the empty and the full set, duplicate
// inserts, refused inserts and the unused mode, with random idles and stalls
// on both channels.
// ----------------------------------------------------------------------------
module tb_sorted_key_set_engine;

    localparam int SET_CAP = 1024;
    localparam int CNT_W   = $clog2(SET_CAP + 1);
    localparam int RAND_REQUESTS = 100;
    localparam int HOLD_AT = 220;       // request count at which the long stall starts
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int PRINT_LIMIT = 40;

    // Mode 3 has no function; the engine must leave the set untouched.
    localparam logic [skse_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [skse_pkg::MODE_W-1:0] mode;
        logic [skse_pkg::KEY_W-1:0]  key;
        int                gap;    // idle cycles after this request is accepted
        bit                drain;  // hold this request until every result is back
    } request_t;

    typedef struct {
        logic             success;
        logic             set_full;
        logic [CNT_W-1:0] key_count;
    } result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [skse_pkg::MODE_W-1:0] mode = '0;
    logic [skse_pkg::KEY_W-1:0] key = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             success;
    logic             set_full;
    logic [CNT_W-1:0] key_count;

    request_t pending_requests[$];
    result_t  expected_results[$];

    // Shadow of the key set. Ordering does not affect any result, so a
    // membership table and a count are enough to predict the engine.
    bit          key_held[bit [skse_pkg::KEY_W-1:0]];
    int unsigned held_total = 0;

    int sent_cnt = 0;
    int recv_cnt = 0;
    int err_cnt = 0;
    int total_requests = -1;
    int gap_left = 0;
    int rx_wait = 0;
    bit hold_off = 1'b0;
    request_t next_req;
    result_t  want;

    sorted_key_set_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .success   (success),
        .set_full  (set_full),
        .key_count (key_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one request to the shadow set and returns what the engine
    // should answer.
    function automatic result_t apply_set_request(logic [skse_pkg::MODE_W-1:0] m,
                                                  logic [skse_pkg::KEY_W-1:0] k);
        result_t r;
        r.success  = 1'b0;
        r.set_full = 1'b0;
        case (m)
            skse_pkg::MODE_MEMBER:
            begin
                r.success = key_held.exists(k) != 0;
            end
            skse_pkg::MODE_INSERT:
            begin
                // A key already held is never refused, even in a full set.
                if (!key_held.exists(k))
                begin
                    if (held_total >= SET_CAP)
                    begin
                        r.set_full = 1'b1;
                    end
                    else
                    begin
                        key_held[k] = 1'b1;
                        held_total++;
                        r.success = 1'b1;
                    end
                end
            end
            skse_pkg::MODE_DELETE:
            begin
                if (key_held.exists(k))
                begin
                    key_held.delete(k);
                    held_total--;
                    r.success = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.key_count = held_total[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int exp_val);
        if (err_cnt < PRINT_LIMIT)
        begin
            $display("%0t: result %0d %s: got %0d, expected %0d",
                     $realtime, recv_cnt, what, got, exp_val);
        end
        err_cnt++;
    endtask

    task automatic queue_request(logic [skse_pkg::MODE_W-1:0] m,
                                 logic [skse_pkg::KEY_W-1:0] k,
                                 int gap, bit drain);
        request_t r;
        r.mode  = m;
        r.key   = k;
        r.gap   = gap;
        r.drain = drain;
        pending_requests.push_back(r);
    endtask

    // Request side. A request stays on the bus until its transfer; the idle
    // count of a request runs after it has been taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode     <= '0;
            key      <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(apply_set_request(mode, key));
                sent_cnt <= sent_cnt + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].drain &&
                           ((in_valid && in_ready) || sent_cnt != recv_cnt)))
                begin
                    next_req = pending_requests.pop_front();
                    mode     <= next_req.mode;
                    key      <= next_req.key;
                    gap_left <= next_req.gap;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side. Every transfer is checked against the oldest prediction,
    // then the next stall length is drawn. Every third stretch of 128
    // results runs without stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("arrived with nothing pending", 1, 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (success !== want.success)
                    begin
                        report_mismatch("success", int'(success), int'(want.success));
                    end
                    if (set_full !== want.set_full)
                    begin
                        report_mismatch("set_full", int'(set_full), int'(want.set_full));
                    end
                    if (key_count !== want.key_count)
                    begin
                        report_mismatch("key_count", int'(key_count),
                                        int'(want.key_count));
                    end
                end
                recv_cnt <= recv_cnt + 1;
            end

            if (hold_off)
            begin
                out_ready <= 1'b0;
            end
            else if (out_valid && out_ready)
            begin
                if (((recv_cnt >> 7) % 3) == 0)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    rx_wait   <= $urandom_range(0, 10);
                    out_ready <= 1'b0;
                end
            end
            else if (!out_ready)
            begin
                if (rx_wait == 0)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    rx_wait <= rx_wait - 1;
                end
            end
        end
    end

    // Long stall on the result side while the fill sequence keeps offering
    // requests back to back, so the engine backs up into its input.
    initial
    begin
        do
        begin
            @(posedge clk);
        end
        while (sent_cnt < HOLD_AT);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        int               order[SET_CAP];
        bit [5:0]         fill_off[SET_CAP];
        logic [skse_pkg::KEY_W-1:0] recent[16];
        logic [skse_pkg::KEY_W-1:0] k;
        logic [skse_pkg::MODE_W-1:0] m;
        int               i;
        int               j;
        int               t;
        int               r;
        int               gap;

        // Fill keys: one key from each block of 64, so all 1024 are distinct
        // and every key bit takes both values.
        for (i = 0; i < SET_CAP; i++)
        begin
            order[i]    = i;
            fill_off[i] = 6'($urandom_range(0, 63));
        end
        for (i = SET_CAP - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (i = 0; i < 16; i++)
        begin
            recent[i] = 16'($urandom_range(0, 16'hFFFF));
        end

        // Empty set, first keys, duplicates, both ends of the key range.
        queue_request(skse_pkg::MODE_MEMBER, 16'h0000, 0, 1'b0);
        queue_request(skse_pkg::MODE_DELETE, 16'hFFFF, 1, 1'b0);
        queue_request(MODE_UNUSED, 16'h1234, 0, 1'b0);
        queue_request(skse_pkg::MODE_INSERT, 16'h8000, 0, 1'b0);
        queue_request(skse_pkg::MODE_INSERT, 16'h0000, 2, 1'b0);
        queue_request(skse_pkg::MODE_INSERT, 16'hFFFF, 0, 1'b0);
        queue_request(skse_pkg::MODE_INSERT, 16'h8000, 0, 1'b0);
        queue_request(skse_pkg::MODE_MEMBER, 16'h8000, 0, 1'b0);
        queue_request(skse_pkg::MODE_MEMBER, 16'h7FFF, 3, 1'b0);
        queue_request(skse_pkg::MODE_DELETE, 16'h0000, 0, 1'b0);
        queue_request(skse_pkg::MODE_DELETE, 16'h0000, 0, 1'b0);
        queue_request(skse_pkg::MODE_DELETE, 16'hFFFF, 0, 1'b0);
        queue_request(skse_pkg::MODE_INSERT, 16'h5555, 0, 1'b0);
        queue_request(skse_pkg::MODE_INSERT, 16'hAAAA, 0, 1'b0);
        queue_request(skse_pkg::MODE_MEMBER, 16'hAAAA, 0, 1'b0);
        queue_request(MODE_UNUSED, 16'hAAAA, 0, 1'b0);
        queue_request(skse_pkg::MODE_DELETE, 16'h8000, 0, 1'b0);
        queue_request(skse_pkg::MODE_DELETE, 16'h5555, 0, 1'b0);
        queue_request(skse_pkg::MODE_DELETE, 16'hAAAA, 4, 1'b0);
        queue_request(skse_pkg::MODE_MEMBER, 16'hAAAA, 0, 1'b1);

        // Fill to capacity in random order. The first part runs back to
        // back so the long result stall backs up the engine.
        for (i = 0; i < SET_CAP; i++)
        begin
            gap = (i < 400 || ((i / 100) % 3) == 1) ? 0 : $urandom_range(0, 10);
            queue_request(skse_pkg::MODE_INSERT, {order[i][9:0], fill_off[order[i]]}, gap,
                          i == 600);
        end

        // Full set: refused insert of an absent key, duplicate insert, and a
        // delete that makes room for exactly one more key.
        queue_request(skse_pkg::MODE_INSERT, {10'd0, fill_off[0] + 6'd1}, 0, 1'b1);
        queue_request(skse_pkg::MODE_INSERT, {10'd5, fill_off[5]}, 0, 1'b0);
        queue_request(MODE_UNUSED, 16'hFFFF, 0, 1'b0);
        queue_request(skse_pkg::MODE_MEMBER, {10'd1023, fill_off[1023]}, 0, 1'b0);
        queue_request(skse_pkg::MODE_DELETE, {10'd7, fill_off[7]}, 0, 1'b0);
        queue_request(skse_pkg::MODE_INSERT, {10'd7, fill_off[7] + 6'd1}, 0, 1'b0);
        queue_request(skse_pkg::MODE_INSERT, {10'd7, fill_off[7]}, 0, 1'b0);

        // Random traffic: the first half leans toward deletes, the second
        // toward inserts, so the count moves away from capacity and back
        // toward it.
        for (i = 0; i < RAND_REQUESTS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                t = $urandom_range(0, SET_CAP - 1);
                k = {t[9:0], fill_off[t]};
            end
            else if (r < 70)
            begin
                k = recent[$urandom_range(0, 15)];
            end
            else if (r < 75)
            begin
                k = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            else
            begin
                k = 16'($urandom_range(0, 16'hFFFF));
            end
            recent[i % 16] = k;

            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                m = skse_pkg::MODE_MEMBER;
            end
            else if (r < ((i < RAND_REQUESTS / 2) ? 40 : 75))
            begin
                m = skse_pkg::MODE_INSERT;
            end
            else if (r < 95)
            begin
                m = skse_pkg::MODE_DELETE;
            end
            else
            begin
                m = MODE_UNUSED;
            end

            gap = (((i / 100) % 3) == 1) ? 0 : $urandom_range(0, 10);
            queue_request(m, k, gap, i == 0 || i == RAND_REQUESTS / 2);
        end
        total_requests = pending_requests.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
        begin
            @(posedge clk);
        end
        while (sent_cnt != total_requests || recv_cnt != sent_cnt);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            report_mismatch("results never arrived", 0, expected_results.size());
        end
        if (err_cnt == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout: %0d requests sent, %0d results received",
                 sent_cnt, recv_cnt);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sorted_key_set_engine.f
sv/skse_pkg.sv
sv/skse_cell.sv
sv/sorted_key_set_engine.sv
bench/tb_sorted_key_set_engine.sv
